/* rtl/assert_macros.svh */
// assertion macros shared by the rtl of the modular exponentiation block
// no dependencies; each macro samples on i_clk and is disabled in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(label, cond, msg) \
    `ASSERT_CLK(label, !(cond), msg)

`endif

/* rtl/modexp_pkg.sv */
// package of the modular exponentiation block: word width and register indexes
// used by modular_exponentiation_top; depends on nothing
`timescale 1ns / 1ps

package modexp_pkg;

    // data word width of modulus, exponent, value and result
    localparam int WORD_W    = 32;
    // bit position counter width
    localparam int CNT_W     = $clog2(WORD_W);
    // width of the add/subtract path in the serial multiplier
    localparam int DP_W      = WORD_W + 2;
    // configuration register index width
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = CFG_IDX_W'(1);

    // register reset values
    localparam logic [WORD_W-1:0] MODULUS_RST  = WORD_W'(2);
    localparam logic [WORD_W-1:0] EXPONENT_RST = '0;

endpackage

/* rtl/modular_exponentiation_top.sv */
// modular exponentiation top level: value ** exponent mod modulus, bit serial
// depends on modexp_pkg and assert_macros.svh
// steps: base reduction, then for each exponent bit from the msb a squaring and, for a set
// bit, a multiply by the base, then the move to the output register once it is free; an
// exponent of zero or a modulus below two skips to that move. one request at a time, the
// serial add/subtract unit sets the rate. sync active low reset: modulus 2, exponent 0, idle
`timescale 1ns / 1ps
`include "assert_macros.svh"

module modular_exponentiation_top
    import modexp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input request channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [WORD_W-1:0]    i_value_in,
    // result request channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [WORD_W-1:0]    o_value_out,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_REDUCE = 5'b00010,
        S_SQUARE = 5'b00100,
        S_MULT   = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic               r_out_valid, n_out_valid;
    logic [WORD_W-1:0]  r_modulus, n_modulus;
    logic [WORD_W-1:0]  r_exponent, n_exponent;
    logic [CNT_W-1:0]   r_step_cnt, n_step_cnt;
    logic [CNT_W-1:0]   r_bit_cnt, n_bit_cnt;

    logic [WORD_W-1:0]  r_acc, n_acc;
    logic [WORD_W-1:0]  r_base, n_base;
    logic [WORD_W-1:0]  r_exp_shift, n_exp_shift;
    logic [WORD_W-1:0]  r_prod, n_prod;
    logic [WORD_W-1:0]  r_mul_b, n_mul_b;
    logic [WORD_W-1:0]  r_out, n_out;

    logic [WORD_W-1:0]  mm_a;
    logic               mm_bit;
    logic [DP_W-1:0]    mm_sum;
    logic [DP_W:0]      mm_sub1;
    logic [DP_W:0]      mm_sub2;
    logic [WORD_W-1:0]  mm_res;
    logic               step_last;
    logic               bit_last;

    // handshake outputs
    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_value_out = r_out;
    assign o_cfg_ready = 1'b1;

    // serial modular multiply step: r <- (2r + bit * a) mod m
    // reduction of the base uses the same step with a = 1
    always_comb begin
        unique case (r_state)
            S_REDUCE: mm_a = WORD_W'(1);
            S_SQUARE: mm_a = r_acc;
            default:  mm_a = r_base;
        endcase
    end

    assign mm_bit  = r_mul_b[WORD_W-1];
    assign mm_sum  = {1'b0, r_prod, 1'b0} + {2'b00, (mm_bit ? mm_a : '0)};
    assign mm_sub1 = {1'b0, mm_sum} - {3'b000, r_modulus};
    assign mm_sub2 = {1'b0, mm_sum} - {2'b00, r_modulus, 1'b0};

    // pick the one candidate that lands in [0, m)
    always_comb begin
        priority if (!mm_sub2[DP_W]) begin
            mm_res = mm_sub2[WORD_W-1:0];
        end else if (!mm_sub1[DP_W]) begin
            mm_res = mm_sub1[WORD_W-1:0];
        end else begin
            mm_res = mm_sum[WORD_W-1:0];
        end
    end

    assign step_last = (r_step_cnt == '0);
    assign bit_last  = (r_bit_cnt == CNT_W'(WORD_W - 1));

    // sequencer and datapath next state
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_modulus   = r_modulus;
        n_exponent  = r_exponent;
        n_step_cnt  = r_step_cnt;
        n_bit_cnt   = r_bit_cnt;
        n_acc       = r_acc;
        n_base      = r_base;
        n_exp_shift = r_exp_shift;
        n_prod      = r_prod;
        n_mul_b     = r_mul_b;
        n_out       = r_out;

        // configuration writes, indexes past the list are dropped
        if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_MODULUS) begin
                n_modulus = i_cfg_data;
            end else if (i_cfg_index == REG_EXPONENT) begin
                n_exponent = i_cfg_data;
            end
        end

        // result taken downstream
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_exp_shift = r_exponent;
                    n_bit_cnt   = '0;
                    if (r_exponent == '0) begin
                        n_acc   = WORD_W'(1);
                        n_state = S_DONE;
                    end else if (r_modulus < WORD_W'(2)) begin
                        n_acc   = '0;
                        n_state = S_DONE;
                    end else begin
                        n_prod     = '0;
                        n_mul_b    = i_value_in;
                        n_step_cnt = CNT_W'(WORD_W - 1);
                        n_state    = S_REDUCE;
                    end
                end
            end
            S_REDUCE: begin
                n_prod     = mm_res;
                n_mul_b    = {r_mul_b[WORD_W-2:0], 1'b0};
                n_step_cnt = r_step_cnt - CNT_W'(1);
                if (step_last) begin
                    n_base     = mm_res;
                    n_acc      = WORD_W'(1);
                    n_prod     = '0;
                    n_mul_b    = WORD_W'(1);
                    n_step_cnt = CNT_W'(WORD_W - 1);
                    n_state    = S_SQUARE;
                end
            end
            S_SQUARE: begin
                n_prod     = mm_res;
                n_mul_b    = {r_mul_b[WORD_W-2:0], 1'b0};
                n_step_cnt = r_step_cnt - CNT_W'(1);
                if (step_last) begin
                    n_acc      = mm_res;
                    n_prod     = '0;
                    n_step_cnt = CNT_W'(WORD_W - 1);
                    if (r_exp_shift[WORD_W-1]) begin
                        // multiplier bits come from the squared accumulator, a is the base
                        n_mul_b = mm_res;
                        n_state = S_MULT;
                    end else begin
                        // next exponent bit
                        n_exp_shift = {r_exp_shift[WORD_W-2:0], 1'b0};
                        n_bit_cnt   = r_bit_cnt + CNT_W'(1);
                        n_mul_b     = mm_res;
                        n_state     = bit_last ? S_DONE : S_SQUARE;
                    end
                end
            end
            S_MULT: begin
                n_prod     = mm_res;
                n_mul_b    = {r_mul_b[WORD_W-2:0], 1'b0};
                n_step_cnt = r_step_cnt - CNT_W'(1);
                if (step_last) begin
                    // next exponent bit
                    n_acc       = mm_res;
                    n_prod      = '0;
                    n_step_cnt  = CNT_W'(WORD_W - 1);
                    n_exp_shift = {r_exp_shift[WORD_W-2:0], 1'b0};
                    n_bit_cnt   = r_bit_cnt + CNT_W'(1);
                    n_mul_b     = mm_res;
                    n_state     = bit_last ? S_DONE : S_SQUARE;
                end
            end
            S_DONE: begin
                // move the result out once the output register is free
                if (!r_out_valid || !i_stall) begin
                    n_out       = r_acc;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_modulus   <= MODULUS_RST;
            r_exponent  <= EXPONENT_RST;
            r_step_cnt  <= '0;
            r_bit_cnt   <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_modulus   <= n_modulus;
            r_exponent  <= n_exponent;
            r_step_cnt  <= n_step_cnt;
            r_bit_cnt   <= n_bit_cnt;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_acc       <= n_acc;
        r_base      <= n_base;
        r_exp_shift <= n_exp_shift;
        r_prod      <= n_prod;
        r_mul_b     <= n_mul_b;
        r_out       <= n_out;
    end

    // an accepted request always starts work
    `ASSERT_CLK(a_accept_starts, (i_valid && !o_stall) |=> (r_state != S_IDLE), "accepted request left the block idle")
    // no exponent bit is consumed while the base is reduced
    `ASSERT_CLK(a_reduce_no_bits, (r_state == S_REDUCE) |-> (r_bit_cnt == '0), "exponent bit counted during base reduction")
    // a free output register takes the finished result in the next cycle
    `ASSERT_CLK(a_done_drains, ((r_state == S_DONE) && !(r_out_valid && i_stall)) |=> (r_out_valid && (r_state == S_IDLE)), "finished result not moved to output")
    // a multiply only ever follows a square
    `ASSERT_NEVER(a_mult_entry, (r_state == S_MULT) && ($past(r_state) != S_MULT) && ($past(r_state) != S_SQUARE), "multiply entered without a square")

endmodule
